// File: hdl/swap_slot_allocator_core_macros.svh
// ----------------------------------------------------------------------------
// Swap slot allocator assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SWAP_SLOT_ALLOCATOR_CORE_MACROS_SVH
`define SWAP_SLOT_ALLOCATOR_CORE_MACROS_SVH

// Property that must hold at every edge out of reset.
`define SSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define SSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ssa_pkg.sv
// ----------------------------------------------------------------------------
// Swap slot allocator package
// Sizes, status and register codes, and the bitmap RAM request bundle.
// ----------------------------------------------------------------------------
package ssa_pkg;

  localparam int NUM_AREAS      = 4;
  localparam int SLOTS_PER_AREA = 1024;
  localparam int WORD_BITS      = 64;
  localparam int WORDS_PER_AREA = (SLOTS_PER_AREA + WORD_BITS - 1) / WORD_BITS;
  localparam int AREA_W         = $clog2(NUM_AREAS);
  localparam int WORD_IDX_W     = $clog2(WORDS_PER_AREA);
  localparam int BIT_IDX_W      = $clog2(WORD_BITS);
  localparam int SLOT_W         = WORD_IDX_W + BIT_IDX_W;
  localparam int ADDR_W         = AREA_W + WORD_IDX_W;
  localparam int DEPTH          = NUM_AREAS * WORDS_PER_AREA;
  localparam int CNT_W          = 11;
  localparam int PRIO_W         = 8;
  localparam int ENTRY_W        = 22;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 11;

  // entry encoding
  localparam int AREA_SHIFT     = 7;
  localparam int AREA_FIELD_W   = 5;
  localparam int SLOT_SHIFT     = 12;
  localparam int SLOT_FIELD_W   = 36;

  typedef enum logic [1:0] {
    STAT_ALLOC   = 2'd0,
    STAT_NOSPACE = 2'd1,
    STAT_FREED   = 2'd2,
    STAT_IGNORED = 2'd3
  } status_e;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRIO0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIO1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIO2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIO3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS  = 3'd5;

  // request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
  } ram_req_t;

endpackage

// File: hdl/ssa_bitmap_ram.sv
// ----------------------------------------------------------------------------
// Swap slot allocator bitmap RAM
// One-port-write, one-port-read word RAM with per-row valid bits; an unwritten
// row reads as all zero (every slot free) after reset.
// ----------------------------------------------------------------------------
module ssa_bitmap_ram import ssa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ram_req_t             req_i,
  output logic [WORD_BITS-1:0] rd_data_o
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_q;
  logic [DEPTH-1:0]     row_vld_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        row_vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= row_vld_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

// File: hdl/swap_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// Swap slot allocator core
// Allocate: ALLOC_RD and ALLOC_CHK per bitmap word scanned (16 words per area),
// then EMIT; free of a valid entry: FREE_RD, FREE_CHK, EMIT; no area to pick or
// ignored free: straight to EMIT. One request at a time: s_axis_tready returns
// as the result is loaded into the output register, after any wait of the
// previous result on m_axis_tready. The scan is set by the one RAM read port.
// Reset clears the bitmaps at once (row valid bits) and the counts, and resets config.
// ----------------------------------------------------------------------------
`include "swap_slot_allocator_core_macros.svh"

module swap_slot_allocator_core import ssa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [47:0]           s_axis_tdata,   // [47:0] free_entry
  input  logic                  s_axis_tuser,   // [0] req_type
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [39:0]           m_axis_tdata,   // [21:0] alloc entry, [23:22] area_index,
                                                // [33:24] slot_index, [39:34] zero
  output logic [1:0]            m_axis_tuser    // [1:0] status
);

  // Sequencer codes
  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_ALLOC_RD  = 3'd1;
  localparam logic [2:0] ST_ALLOC_CHK = 3'd2;
  localparam logic [2:0] ST_FREE_RD   = 3'd3;
  localparam logic [2:0] ST_FREE_CHK  = 3'd4;
  localparam logic [2:0] ST_EMIT      = 3'd5;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(SLOTS_PER_AREA);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [PRIO_W-1:0]    prio_q [NUM_AREAS];
  logic [NUM_AREAS-1:0] active_q;
  logic [CNT_W-1:0]     slots_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AREAS; i++) begin
        prio_q[i] <= '0;
      end
      active_q <= '0;
      slots_q  <= CNT_MAX;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PRIO0:  prio_q[0] <= cfg_data_i[PRIO_W-1:0];
        CFG_PRIO1:  prio_q[1] <= cfg_data_i[PRIO_W-1:0];
        CFG_PRIO2:  prio_q[2] <= cfg_data_i[PRIO_W-1:0];
        CFG_PRIO3:  prio_q[3] <= cfg_data_i[PRIO_W-1:0];
        CFG_ACTIVE: active_q  <= cfg_data_i[NUM_AREAS-1:0];
        CFG_SLOTS:  slots_q   <= cfg_data_i;
        default: ;  // unknown index, dropped
      endcase
    end
  end

  // usable slots per area, capped at the physical size
  logic [CNT_W-1:0] pages;
  logic [CNT_W-1:0] pages_m1;
  assign pages    = (slots_q > CNT_MAX) ? CNT_MAX : slots_q;
  assign pages_m1 = pages - CNT_W'(1);

  // --------------------------------------------------------------------------
  // Sequencer and datapath registers
  // --------------------------------------------------------------------------
  logic [2:0]            state_q, state_d;
  logic [CNT_W-1:0]      used_q [NUM_AREAS];
  logic [AREA_W-1:0]     area_q;
  logic [WORD_IDX_W-1:0] word_q;
  logic [WORD_IDX_W-1:0] last_word_q;
  logic [WORD_BITS-1:0]  lim_mask_q;   // slots past the usable count, last word only
  logic [SLOT_W-1:0]     slot_q;
  status_e               res_status_q;
  logic [ENTRY_W-1:0]    res_entry_q;
  logic [AREA_W-1:0]     res_area_q;
  logic [SLOT_W-1:0]     res_slot_q;
  logic                  m_valid_q;
  status_e               out_status_q;
  logic [ENTRY_W-1:0]    out_entry_q;
  logic [AREA_W-1:0]     out_area_q;
  logic [SLOT_W-1:0]     out_slot_q;

  logic                  accept;
  logic                  out_free;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  // --------------------------------------------------------------------------
  // Area pick: highest priority among active areas with room, ties to higher
  // --------------------------------------------------------------------------
  logic              have_area;
  logic [AREA_W-1:0] best_area;
  logic [PRIO_W-1:0] best_prio;

  always_comb begin
    have_area = 1'b0;
    best_area = '0;
    best_prio = '0;
    for (int i = 0; i < NUM_AREAS; i++) begin
      if (active_q[i] && (used_q[i] < pages) && (prio_q[i] >= best_prio)) begin
        have_area = 1'b1;
        best_area = AREA_W'(i);
        best_prio = prio_q[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Free entry decode
  // --------------------------------------------------------------------------
  logic [AREA_FIELD_W-1:0] fe_area;
  logic [SLOT_FIELD_W-1:0] fe_slot;
  logic                    fe_ok;

  assign fe_area = s_axis_tdata[AREA_SHIFT +: AREA_FIELD_W];
  assign fe_slot = s_axis_tdata[SLOT_SHIFT +: SLOT_FIELD_W];
  assign fe_ok   = s_axis_tdata[0]
                && (fe_area < AREA_FIELD_W'(NUM_AREAS))
                && active_q[fe_area[AREA_W-1:0]]
                && (fe_slot[SLOT_FIELD_W-1:CNT_W] == '0)
                && (fe_slot[CNT_W-1:0] < pages);

  // --------------------------------------------------------------------------
  // Shared word unit: lowest clear bit through ~w & (w+1) style one-hot
  // --------------------------------------------------------------------------
  logic [WORD_BITS-1:0] rd_data;
  logic [WORD_BITS-1:0] scan_word;
  logic [WORD_BITS-1:0] scan_inc;
  logic [WORD_BITS-1:0] scan_oh;
  logic                 scan_hit;
  logic [BIT_IDX_W-1:0] scan_idx;
  logic [WORD_BITS-1:0] free_bit;
  logic                 free_set;

  assign scan_word = rd_data | ((word_q == last_word_q) ? lim_mask_q : '0);
  assign scan_inc  = scan_word + WORD_BITS'(1);
  assign scan_oh   = ~scan_word & scan_inc;
  assign scan_hit  = |scan_oh;

  always_comb begin
    scan_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (scan_oh[i]) begin
        scan_idx = scan_idx | BIT_IDX_W'(i);
      end
    end
  end

  assign free_bit = WORD_BITS'(1) << slot_q[BIT_IDX_W-1:0];
  assign free_set = |(rd_data & free_bit);

  // --------------------------------------------------------------------------
  // Bitmap RAM
  // --------------------------------------------------------------------------
  ram_req_t ram_req;

  always_comb begin
    ram_req.rd_en   = (state_q == ST_ALLOC_RD) || (state_q == ST_FREE_RD);
    ram_req.wr_en   = ((state_q == ST_ALLOC_CHK) && scan_hit)
                   || ((state_q == ST_FREE_CHK) && free_set);
    if ((state_q == ST_FREE_RD) || (state_q == ST_FREE_CHK)) begin
      ram_req.rd_addr = {area_q, slot_q[SLOT_W-1:BIT_IDX_W]};
      ram_req.wr_addr = {area_q, slot_q[SLOT_W-1:BIT_IDX_W]};
      ram_req.wr_data = rd_data & ~free_bit;
    end else begin
      ram_req.rd_addr = {area_q, word_q};
      ram_req.wr_addr = {area_q, word_q};
      ram_req.wr_data = rd_data | scan_oh;
    end
  end

  ssa_bitmap_ram u_bitmap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ram_req),
    .rd_data_o (rd_data)
  );

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == REQ_ALLOC) begin
            state_d = have_area ? ST_ALLOC_RD : ST_EMIT;
          end else begin
            state_d = fe_ok ? ST_FREE_RD : ST_EMIT;
          end
        end
      end
      ST_ALLOC_RD:  state_d = ST_ALLOC_CHK;
      ST_ALLOC_CHK: begin
        if (scan_hit || (word_q == last_word_q)) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_ALLOC_RD;
        end
      end
      ST_FREE_RD:   state_d = ST_FREE_CHK;
      ST_FREE_CHK:  state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  // control: state, counts, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      for (int i = 0; i < NUM_AREAS; i++) begin
        used_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if ((state_q == ST_ALLOC_CHK) && scan_hit) begin
        used_q[area_q] <= used_q[area_q] + CNT_W'(1);
      end
      if ((state_q == ST_FREE_CHK) && free_set && (used_q[area_q] != '0)) begin
        used_q[area_q] <= used_q[area_q] - CNT_W'(1);
      end
      if ((state_q == ST_EMIT) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          word_q       <= '0;
          last_word_q  <= pages_m1[SLOT_W-1:BIT_IDX_W];
          lim_mask_q   <= (pages[BIT_IDX_W-1:0] == '0) ? '0
                        : ~((WORD_BITS'(1) << pages[BIT_IDX_W-1:0]) - WORD_BITS'(1));
          slot_q       <= fe_slot[SLOT_W-1:0];
          area_q       <= (s_axis_tuser == REQ_ALLOC) ? best_area
                                                      : fe_area[AREA_W-1:0];
          res_status_q <= (s_axis_tuser == REQ_ALLOC) ? STAT_NOSPACE : STAT_IGNORED;
          res_entry_q  <= '0;
          res_area_q   <= '0;
          res_slot_q   <= '0;
        end
      end
      ST_ALLOC_CHK: begin
        if (scan_hit) begin
          res_status_q <= STAT_ALLOC;
          res_entry_q  <= {word_q, scan_idx,
                           (AREA_FIELD_W - AREA_W)'(0), area_q,
                           (AREA_SHIFT - 1)'(0), 1'b1};
          res_area_q   <= area_q;
          res_slot_q   <= {word_q, scan_idx};
        end else begin
          word_q       <= word_q + WORD_IDX_W'(1);
        end
      end
      ST_FREE_CHK: begin
        if (free_set) begin
          res_status_q <= STAT_FREED;
          res_area_q   <= area_q;
          res_slot_q   <= slot_q;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_status_q <= res_status_q;
          out_entry_q  <= res_entry_q;
          out_area_q   <= res_area_q;
          out_slot_q   <= res_slot_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {6'b0, out_slot_q, out_area_q, out_entry_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `SSA_ASSERT(a_ram_wr_in_chk,
    ram_req.wr_en |-> (state_q == ST_ALLOC_CHK || state_q == ST_FREE_CHK),
    "bitmap write outside a check step")
  `SSA_ASSERT(a_count_bound,
    (used_q[0] <= CNT_MAX) && (used_q[1] <= CNT_MAX)
      && (used_q[2] <= CNT_MAX) && (used_q[3] <= CNT_MAX),
    "used count above area size")
  `SSA_ASSERT_NEXT(a_accept_busy, accept, state_q != ST_IDLE,
    "sequencer idle right after accept")
  `SSA_ASSERT(a_alloc_entry,
    (m_axis_tvalid && m_axis_tuser == STAT_ALLOC) |-> (out_entry_q[0]
      && out_entry_q[SLOT_SHIFT +: SLOT_W] == out_slot_q
      && out_entry_q[AREA_SHIFT +: AREA_W] == out_area_q),
    "allocated entry does not match area and slot")

endmodule
